// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define FPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check an implication on every clock edge outside reset
`define FPA_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

`endif

// ----- src/fpa_pkg.sv -----
// ----------------------------------------------------------------------------
// fpa_pkg
// Action and status codes and the sideband record of the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

  typedef enum logic [3:0] {
    ACT_ADD      = 4'd0,
    ACT_SUB      = 4'd1,
    ACT_MUL      = 4'd2,
    ACT_DIV      = 4'd3,
    ACT_GT       = 4'd4,
    ACT_LT       = 4'd5,
    ACT_GE       = 4'd6,
    ACT_LE       = 4'd7,
    ACT_EQ       = 4'd8,
    ACT_NE       = 4'd9,
    ACT_MIN      = 4'd10,
    ACT_MAX      = 4'd11,
    ACT_INC      = 4'd12,
    ACT_DEC      = 4'd13,
    ACT_FROM_INT = 4'd14,
    ACT_TO_INT   = 4'd15
  } action_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIVZ = 2'd2
  } status_e;

  typedef struct packed {
    action_e act;
    status_e st;
    logic    cmp;
    logic    neg;
  } side_t;

endpackage

// ----- src/q24_8_fixed_point_alu_unit.sv -----
// ----------------------------------------------------------------------------
// q24_8_fixed_point_alu_unit
// Pipelined signed fixed-point ALU with saturation and rounded mul/div.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries action_i, operand_a_i and
//   operand_b_i; output channel out_valid_o/out_ready_i carries result_o,
//   compare_true_o and status_o, one item out per item in, in order.
//   The pipe is one entry stage, one stage per quotient bit of the restoring
//   divider, then a rounding stage and the output register. Every action
//   takes the same path, so while the receiver does not stall, one item is
//   accepted per cycle and one leaves per cycle.
//   The divider chain sets the depth.
//   Reset clears every stage valid bit; the pipe comes out empty.
//   When the receiver stalls with a result waiting, the whole pipe holds and
//   in_ready_o drops in the same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module q24_8_fixed_point_alu_unit #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [3:0]           action_i,
  input  logic [WORD_BITS-1:0] operand_a_i,
  input  logic [WORD_BITS-1:0] operand_b_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [WORD_BITS-1:0] result_o,
  output logic                 compare_true_o,
  output logic [1:0]           status_o
);
  import fpa_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int QB = WORD_BITS + FRAC_BITS;
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic en;

  logic          v   [QB+1];
  side_t         sd  [QB+1];
  logic [W-1:0]  rs  [QB+1];
  logic [W-1:0]  ma  [QB+1];
  logic [W-1:0]  dd  [QB+1];
  logic [QB-1:0] nn  [QB+1];
  logic [W-1:0]  rr  [QB+1];
  logic [QB-1:0] qq  [QB+1];

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  fpa_front #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .action_i (action_i),
    .a_i      (operand_a_i),
    .b_i      (operand_b_i),
    .valid_o  (v[0]),
    .side_o   (sd[0]),
    .res_o    (rs[0]),
    .ma_o     (ma[0]),
    .d_o      (dd[0])
  );

  assign nn[0] = {ma[0], {FRAC_BITS{1'b0}}};
  assign rr[0] = '0;
  assign qq[0] = '0;

  for (genvar i = 0; i < QB; i++) begin : g_div
    fpa_div_step #(.WORD_BITS(W), .QB(QB)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v[i]),
      .side_i  (sd[i]),
      .res_i   (rs[i]),
      .ma_i    (ma[i]),
      .d_i     (dd[i]),
      .n_i     (nn[i]),
      .r_i     (rr[i]),
      .q_i     (qq[i]),
      .valid_o (v[i+1]),
      .side_o  (sd[i+1]),
      .res_o   (rs[i+1]),
      .ma_o    (ma[i+1]),
      .d_o     (dd[i+1]),
      .n_o     (nn[i+1]),
      .r_o     (rr[i+1]),
      .q_o     (qq[i+1])
    );
  end

  fpa_back #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS), .QB(QB)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (v[QB]),
    .side_i   (sd[QB]),
    .res_i    (rs[QB]),
    .ma_i     (ma[QB]),
    .d_i      (dd[QB]),
    .r_i      (rr[QB]),
    .q_i      (qq[QB]),
    .valid_o  (out_valid_o),
    .result_o (result_o),
    .cmp_o    (compare_true_o),
    .status_o (status_o)
  );

  `FPA_ASSERT_IMP(a_cmp_zero_res, out_valid_o && compare_true_o, result_o == '0 && status_o == ST_OK, "comparison item with nonzero result")
  `FPA_ASSERT_IMP(a_divz_zero, out_valid_o && status_o == ST_DIVZ, result_o == '0 && !compare_true_o, "division by zero item with nonzero result")
  `FPA_ASSERT_IMP(a_ovf_sat, out_valid_o && status_o == ST_OVF, result_o == MAXV || result_o == MINV, "overflow item not saturated")
  `FPA_ASSERT(a_status_code, !out_valid_o || status_o != 2'd3, "undefined status code")

endmodule

// ----- src/fpa_front.sv -----
// ----------------------------------------------------------------------------
// fpa_front
// Entry stage: results of all actions but mul/div, operand magnitudes and result sign.
// ----------------------------------------------------------------------------
module fpa_front #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [3:0]           action_i,
  input  logic [WORD_BITS-1:0] a_i,
  input  logic [WORD_BITS-1:0] b_i,
  output logic                 valid_o,
  output fpa_pkg::side_t       side_o,
  output logic [WORD_BITS-1:0] res_o,
  output logic [WORD_BITS-1:0] ma_o,
  output logic [WORD_BITS-1:0] d_o
);
  import fpa_pkg::*;

  localparam int W = WORD_BITS;
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0] sum, diff, sat, res_d, ma, mb;
  logic [FRAC_BITS:0] top;
  logic lt, gt, cmp_d;
  status_e st_d;
  action_e act;
  logic valid_q;
  side_t side_q;
  logic [W-1:0] res_q, ma_q, d_q;

  always_comb begin
    act   = action_e'(action_i);
    sum   = a_i + b_i;
    diff  = a_i - b_i;
    sat   = a_i[W-1] ? MINV : MAXV;
    lt    = $signed(a_i) < $signed(b_i);
    gt    = $signed(b_i) < $signed(a_i);
    ma    = a_i[W-1] ? (~a_i + 1'b1) : a_i;
    mb    = b_i[W-1] ? (~b_i + 1'b1) : b_i;
    top   = a_i[W-1 -: FRAC_BITS+1];
    res_d = '0;
    cmp_d = 1'b0;
    st_d  = ST_OK;
    case (act)
      ACT_ADD: begin
        res_d = sum;
        if (a_i[W-1] == b_i[W-1] && sum[W-1] != a_i[W-1]) begin
          res_d = sat;
          st_d  = ST_OVF;
        end
      end
      ACT_SUB: begin
        res_d = diff;
        if (a_i[W-1] != b_i[W-1] && diff[W-1] != a_i[W-1]) begin
          res_d = sat;
          st_d  = ST_OVF;
        end
      end
      ACT_MUL: res_d = '0;
      ACT_DIV: if (b_i == '0) st_d = ST_DIVZ;
      ACT_GT:  cmp_d = gt;
      ACT_LT:  cmp_d = lt;
      ACT_GE:  cmp_d = !lt;
      ACT_LE:  cmp_d = !gt;
      ACT_EQ:  cmp_d = (a_i == b_i);
      ACT_NE:  cmp_d = (a_i != b_i);
      ACT_MIN: res_d = lt ? a_i : b_i;
      ACT_MAX: res_d = gt ? a_i : b_i;
      ACT_INC: begin
        if (a_i == MAXV) begin
          res_d = MAXV;
          st_d  = ST_OVF;
        end else res_d = a_i + 1'b1;
      end
      ACT_DEC: begin
        if (a_i == MINV) begin
          res_d = MINV;
          st_d  = ST_OVF;
        end else res_d = a_i - 1'b1;
      end
      ACT_FROM_INT: begin
        if ((&top) || !(|top)) res_d = a_i << FRAC_BITS;
        else begin
          res_d = sat;
          st_d  = ST_OVF;
        end
      end
      ACT_TO_INT: res_d = W'($signed(a_i) >>> FRAC_BITS);
      default: res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= '{act: act, st: st_d, cmp: cmp_d, neg: a_i[W-1] ^ b_i[W-1]};
      res_q  <= res_d;
      ma_q   <= ma;
      d_q    <= mb;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign res_o   = res_q;
  assign ma_o    = ma_q;
  assign d_o     = d_q;

endmodule

// ----- src/fpa_div_step.sv -----
// ----------------------------------------------------------------------------
// fpa_div_step
// One registered restoring-division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module fpa_div_step #(
  parameter int WORD_BITS = 32,
  parameter int QB        = 40
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  fpa_pkg::side_t       side_i,
  input  logic [WORD_BITS-1:0] res_i,
  input  logic [WORD_BITS-1:0] ma_i,
  input  logic [WORD_BITS-1:0] d_i,
  input  logic [QB-1:0]        n_i,
  input  logic [WORD_BITS-1:0] r_i,
  input  logic [QB-1:0]        q_i,
  output logic                 valid_o,
  output fpa_pkg::side_t       side_o,
  output logic [WORD_BITS-1:0] res_o,
  output logic [WORD_BITS-1:0] ma_o,
  output logic [WORD_BITS-1:0] d_o,
  output logic [QB-1:0]        n_o,
  output logic [WORD_BITS-1:0] r_o,
  output logic [QB-1:0]        q_o
);
  import fpa_pkg::*;

  logic [WORD_BITS:0] trial;
  logic               take;
  logic [WORD_BITS-1:0] r_d;
  logic valid_q;
  side_t side_q;
  logic [WORD_BITS-1:0] res_q, ma_q, d_q, r_q;
  logic [QB-1:0] n_q, q_q;

  always_comb begin
    trial = {r_i, n_i[QB-1]};
    take  = trial >= {1'b0, d_i};
    r_d   = take ? WORD_BITS'(trial - {1'b0, d_i}) : trial[WORD_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      res_q  <= res_i;
      ma_q   <= ma_i;
      d_q    <= d_i;
      n_q    <= n_i << 1;
      r_q    <= r_d;
      q_q    <= {q_i[QB-2:0], take};
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign res_o   = res_q;
  assign ma_o    = ma_q;
  assign d_o     = d_q;
  assign n_o     = n_q;
  assign r_o     = r_q;
  assign q_o     = q_q;

endmodule

// ----- src/fpa_back.sv -----
// ----------------------------------------------------------------------------
// fpa_back
// Product and quotient rounding, saturation, result select; output register.
// ----------------------------------------------------------------------------
module fpa_back #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 8,
  parameter int QB        = 40
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  fpa_pkg::side_t       side_i,
  input  logic [WORD_BITS-1:0] res_i,
  input  logic [WORD_BITS-1:0] ma_i,
  input  logic [WORD_BITS-1:0] d_i,
  input  logic [WORD_BITS-1:0] r_i,
  input  logic [QB-1:0]        q_i,
  output logic                 valid_o,
  output logic [WORD_BITS-1:0] result_o,
  output logic                 cmp_o,
  output logic [1:0]           status_o
);
  import fpa_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int PW = 2*W + 1;
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  // rounding stage
  logic          va_q;
  side_t         sa_q;
  logic [W-1:0]  ra_q;
  logic [2*W-1:0] prod_q;
  logic [QB:0]   qr_q;

  // output stage
  logic          vb_q;
  logic [W-1:0]  res_q, res_d;
  logic          cmp_q;
  status_e       st_q, st_d;

  logic [W:0]    lim;
  logic [PW-1:0] pr, msh;
  logic [W-1:0]  mag;
  logic          ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sa_q   <= side_i;
      ra_q   <= res_i;
      prod_q <= (2*W)'(ma_i) * (2*W)'(d_i);
      qr_q   <= {1'b0, q_i} + (QB+1)'({r_i, 1'b0} >= {1'b0, d_i});
      res_q  <= res_d;
      cmp_q  <= sa_q.cmp;
      st_q   <= st_d;
    end
  end

  always_comb begin
    lim   = (W+1)'(MAXV) + (W+1)'(sa_q.neg);
    pr    = {1'b0, prod_q} + (PW'(1) << (FRAC_BITS - 1));
    msh   = pr >> FRAC_BITS;
    mag   = '0;
    ovf   = 1'b0;
    res_d = ra_q;
    st_d  = sa_q.st;
    case (sa_q.act)
      ACT_MUL: begin
        ovf = msh > PW'(lim);
        mag = msh[W-1:0];
      end
      ACT_DIV: begin
        ovf = qr_q > (QB+1)'(lim);
        mag = qr_q[W-1:0];
      end
      default: ovf = 1'b0;
    endcase
    if ((sa_q.act == ACT_MUL) || (sa_q.act == ACT_DIV && sa_q.st != ST_DIVZ)) begin
      if (ovf) begin
        res_d = sa_q.neg ? MINV : MAXV;
        st_d  = ST_OVF;
      end else begin
        res_d = sa_q.neg ? (~mag + 1'b1) : mag;
      end
    end
  end

  assign valid_o  = vb_q;
  assign result_o = res_q;
  assign cmp_o    = cmp_q;
  assign status_o = st_q;

endmodule
